// ----- hdl/rle8_pkg.sv -----
// Shared types and constants for the RLE8 bitmap encoder.
`default_nettype none

package rle8_pkg;

   // Byte and register widths fixed by the stream format.
   localparam int BYTE_W = 8;
   localparam int CSR_W  = 15;

   // Register indexes on the configuration port.
   typedef enum logic [0:0] {
      CSR_IMAGE_WIDTH  = 1'b0,
      CSR_IMAGE_HEIGHT = 1'b1
   } csr_index_type;

   // Marker bytes that close a row or the whole image.
   localparam logic [BYTE_W-1:0] BYTE_EOL = 8'h00;
   localparam logic [BYTE_W-1:0] BYTE_EOB = 8'h01;

   // Depth of the command queue between the front and back parts.
   localparam int QUEUE_DEPTH = 4;
   localparam int QPTR_W      = 2;

   // Number of bytes one command can expand to.
   localparam int CMD_BYTES = 6;

   // One pixel's worth of work for the back part: up to two run flushes and a
   // row or image marker pair.
   typedef struct packed {
      logic              f1_valid;
      logic [BYTE_W-1:0] f1_count;
      logic [BYTE_W-1:0] f1_value;
      logic              f2_valid;
      logic [BYTE_W-1:0] f2_count;
      logic [BYTE_W-1:0] f2_value;
      logic              mark_valid;
      logic              mark_eob;
   } cmd_type;

   // Queue status seen by the front and back parts.
   typedef struct packed {
      logic full;
      logic empty;
   } queue_status_type;

   function automatic logic [CMD_BYTES-1:0] cmd_mask(input cmd_type cmd);
      cmd_mask = {cmd.mark_valid, cmd.mark_valid, cmd.f2_valid, cmd.f2_valid,
                  cmd.f1_valid, cmd.f1_valid};
   endfunction

endpackage

`default_nettype wire

// ----- hdl/rle8_front.sv -----
// Front part: tracks the open run and the pixel position, builds commands.
`default_nettype none

module rle8_front #(
   parameter int MAX_RUN  = 255,
   parameter int DIM_BITS = 14
) (
   input  wire logic                            clock,
   input  wire logic                            reset,
   input  wire logic                            pixel_accept,
   input  wire logic [rle8_pkg::BYTE_W-1:0]     pixel_value,
   input  wire logic [rle8_pkg::CSR_W-1:0]      image_width,
   input  wire logic [rle8_pkg::CSR_W-1:0]      image_height,
   output rle8_pkg::cmd_type                    cmd,
   output logic                                 cmd_push
);
   import rle8_pkg::*;

   localparam int CMP_W = (DIM_BITS >= CSR_W) ? DIM_BITS + 1 : CSR_W + 1;
   localparam logic [CMP_W-1:0]  DIM_LIMIT = CMP_W'(1) << DIM_BITS;
   localparam logic [BYTE_W-1:0] MAX_RUN_B = BYTE_W'(MAX_RUN);

   logic [BYTE_W-1:0]   held_value_ff, held_value_in;
   logic [BYTE_W-1:0]   run_count_ff, run_count_in;
   logic [DIM_BITS-1:0] column_pos_ff, column_pos_in;
   logic [DIM_BITS-1:0] row_pos_ff, row_pos_in;

   logic [CMP_W-1:0]  width_eff, height_eff;
   logic [CMP_W-1:0]  width_raw, height_raw;
   logic              run_open, value_differs, start_new;
   logic [BYTE_W-1:0] new_count, new_value;
   logic              row_end, image_end;

   always_comb begin
      width_raw  = CMP_W'(image_width);
      height_raw = CMP_W'(image_height);

      // A zero dimension acts as one; an oversized one is capped.
      if (width_raw == '0) begin
         width_eff = CMP_W'(1);
      end else if (width_raw > DIM_LIMIT) begin
         width_eff = DIM_LIMIT;
      end else begin
         width_eff = width_raw;
      end
      if (height_raw == '0) begin
         height_eff = CMP_W'(1);
      end else if (height_raw > DIM_LIMIT) begin
         height_eff = DIM_LIMIT;
      end else begin
         height_eff = height_raw;
      end

      run_open      = (run_count_ff != '0);
      value_differs = run_open && (pixel_value != held_value_ff);
      start_new     = !run_open || value_differs;
      new_count     = start_new ? BYTE_W'(1) : run_count_ff + BYTE_W'(1);
      new_value     = start_new ? pixel_value : held_value_ff;

      row_end   = (CMP_W'(column_pos_ff) + CMP_W'(1)) >= width_eff;
      image_end = (CMP_W'(row_pos_ff) + CMP_W'(1)) >= height_eff;

      cmd.f1_valid   = value_differs;
      cmd.f1_count   = run_count_ff;
      cmd.f1_value   = held_value_ff;
      cmd.f2_valid   = (new_count >= MAX_RUN_B) || row_end;
      cmd.f2_count   = new_count;
      cmd.f2_value   = new_value;
      cmd.mark_valid = row_end;
      cmd.mark_eob   = image_end;

      cmd_push = pixel_accept && (cmd.f1_valid || cmd.f2_valid || cmd.mark_valid);

      held_value_in = held_value_ff;
      run_count_in  = run_count_ff;
      column_pos_in = column_pos_ff;
      row_pos_in    = row_pos_ff;
      if (pixel_accept) begin
         held_value_in = new_value;
         run_count_in  = cmd.f2_valid ? '0 : new_count;
         if (row_end) begin
            column_pos_in = '0;
            row_pos_in    = image_end ? '0 : row_pos_ff + DIM_BITS'(1);
         end else begin
            column_pos_in = column_pos_ff + DIM_BITS'(1);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         held_value_ff <= '0;
         run_count_ff  <= '0;
         column_pos_ff <= '0;
         row_pos_ff    <= '0;
      end else begin
         held_value_ff <= held_value_in;
         run_count_ff  <= run_count_in;
         column_pos_ff <= column_pos_in;
         row_pos_ff    <= row_pos_in;
      end
   end

   // An open run is flushed as soon as it reaches the limit.
   a_run_below_limit: assert property (@(posedge clock) disable iff (reset)
      run_count_ff < MAX_RUN_B)
      else $error("open run reached the run limit");

   // A run never stays open across the end of a row.
   a_row_end_closes_run: assert property (@(posedge clock) disable iff (reset)
      pixel_accept && row_end |=> run_count_ff == '0)
      else $error("run left open after end of row");

   // Every row end goes out as a command.
   a_row_end_pushes: assert property (@(posedge clock) disable iff (reset)
      pixel_accept && row_end |-> cmd_push)
      else $error("row end produced no command");

endmodule

`default_nettype wire

// ----- hdl/rle8_queue.sv -----
// Short command queue between the front and back parts.
`default_nettype none

module rle8_queue (
   input  wire logic                       clock,
   input  wire logic                       reset,
   input  wire logic                       push,
   input  wire rle8_pkg::cmd_type          push_cmd,
   input  wire logic                       pop,
   output rle8_pkg::cmd_type               head_cmd,
   output rle8_pkg::queue_status_type      status
);
   import rle8_pkg::*;

   cmd_type           entries_ff [QUEUE_DEPTH];
   logic [QPTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [QPTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [QPTR_W:0]   count_ff, count_in;

   always_comb begin
      status.full  = (count_ff == (QPTR_W+1)'(QUEUE_DEPTH));
      status.empty = (count_ff == '0);
      head_cmd     = entries_ff[rd_ptr_ff];

      wr_ptr_in = push ? wr_ptr_ff + QPTR_W'(1) : wr_ptr_ff;
      rd_ptr_in = pop ? rd_ptr_ff + QPTR_W'(1) : rd_ptr_ff;
      count_in  = count_ff;
      if (push && !pop) begin
         count_in = count_ff + (QPTR_W+1)'(1);
      end else if (pop && !push) begin
         count_in = count_ff - (QPTR_W+1)'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         entries_ff[wr_ptr_ff] <= push_cmd;
      end
   end

   a_no_push_full: assert property (@(posedge clock) disable iff (reset)
      push |-> !status.full)
      else $error("push into a full queue");

   a_no_pop_empty: assert property (@(posedge clock) disable iff (reset)
      pop |-> !status.empty)
      else $error("pop from an empty queue");

   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= (QPTR_W+1)'(QUEUE_DEPTH))
      else $error("queue count beyond depth");

endmodule

`default_nettype wire

// ----- hdl/rle8_back.sv -----
// Back part: expands queued commands into output bytes, one per cycle while the output is ready.
`default_nettype none

module rle8_back (
   input  wire logic                         clock,
   input  wire logic                         reset,
   input  wire rle8_pkg::cmd_type            head_cmd,
   input  wire rle8_pkg::queue_status_type   status,
   output logic                              pop,
   output logic                              rsp_tvalid,
   input  wire logic                         rsp_tready,
   output logic [rle8_pkg::BYTE_W-1:0]       rsp_tdata,
   output logic                              rsp_tlast
);
   import rle8_pkg::*;

   cmd_type                cmd_ff, cmd_in;
   logic [CMD_BYTES-1:0]   mask_ff, mask_in;
   logic                   valid_ff, valid_in;
   logic [BYTE_W-1:0]      data_ff, data_in;
   logic                   last_ff, last_in;

   logic                   busy, have_work, can_emit, emit;
   cmd_type                cur_cmd;
   logic [CMD_BYTES-1:0]   cur_mask, sel, rest;
   logic [BYTE_W-1:0]      sel_byte;

   always_comb begin
      busy      = (mask_ff != '0);
      have_work = busy || !status.empty;
      can_emit  = !valid_ff || rsp_tready;
      emit      = have_work && can_emit;

      cur_cmd  = busy ? cmd_ff : head_cmd;
      cur_mask = busy ? mask_ff : cmd_mask(head_cmd);
      sel      = cur_mask & (~cur_mask + CMD_BYTES'(1));
      rest     = cur_mask & ~sel;

      if (sel[0]) begin
         sel_byte = cur_cmd.f1_count;
      end else if (sel[1]) begin
         sel_byte = cur_cmd.f1_value;
      end else if (sel[2]) begin
         sel_byte = cur_cmd.f2_count;
      end else if (sel[3]) begin
         sel_byte = cur_cmd.f2_value;
      end else if (sel[4]) begin
         sel_byte = BYTE_EOL;
      end else begin
         sel_byte = cur_cmd.mark_eob ? BYTE_EOB : BYTE_EOL;
      end

      pop      = emit && !busy;
      cmd_in   = emit ? cur_cmd : cmd_ff;
      mask_in  = emit ? rest : mask_ff;
      valid_in = emit ? 1'b1 : (valid_ff && !rsp_tready);
      data_in  = emit ? sel_byte : data_ff;
      last_in  = emit ? (rest == '0) : last_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         mask_ff  <= '0;
         valid_ff <= 1'b0;
      end else begin
         mask_ff  <= mask_in;
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      cmd_ff  <= cmd_in;
      data_ff <= data_in;
      last_ff <= last_in;
   end

   assign rsp_tvalid = valid_ff;
   assign rsp_tdata  = data_ff;
   assign rsp_tlast  = last_ff;

   // Bytes still pending from a command imply one already waits at the output.
   a_pending_has_output: assert property (@(posedge clock) disable iff (reset)
      busy |-> valid_ff)
      else $error("pending bytes without an output beat");

   // A beat that closes a command leaves nothing pending.
   a_last_clears_mask: assert property (@(posedge clock) disable iff (reset)
      emit && rest == '0 |=> !busy)
      else $error("command bytes left after last beat");

   // A command byte that is not the last keeps the back part busy.
   a_not_last_keeps_busy: assert property (@(posedge clock) disable iff (reset)
      emit && rest != '0 |=> busy && valid_ff && !last_ff)
      else $error("command dropped before its last beat");

endmodule

`default_nettype wire

// ----- hdl/rle8_bitmap_encoder_core.sv -----
// Top level of the BMP RLE8 encoder (encoded mode only).
//
//   Channel  Direction  Beat contents
//   req_     in         tdata[7:0] = pixel_value
//   rsp_     out        tdata[7:0] = out_byte, tlast = last_of_item
//   csr_     in         index 0 image_width, index 1 image_height (15 bits each)
//
// A pixel is taken whenever the command queue has room; each pixel yields zero
// to six bytes and the back part sends one byte per cycle while the result port
// accepts, so the output port sets the sustained rate. Reset clears the open run,
// the pixel position and the queue, and sets both dimensions to one. A stalled
// result port fills the four-entry queue before req_tready drops.
`default_nettype none

module rle8_bitmap_encoder_core #(
   parameter int MAX_RUN  = 255,
   parameter int DIM_BITS = 14
) (
   input  wire logic                          clock,
   input  wire logic                          reset,
   // Pixel beats.
   input  wire logic                          req_tvalid,
   output logic                               req_tready,
   input  wire logic [rle8_pkg::BYTE_W-1:0]   req_tdata,   // [7:0] pixel_value
   // Encoded byte beats.
   output logic                               rsp_tvalid,
   input  wire logic                          rsp_tready,
   output logic [rle8_pkg::BYTE_W-1:0]        rsp_tdata,   // [7:0] out_byte
   output logic                               rsp_tlast,   // last_of_item
   // Configuration writes.
   input  wire logic                          csr_we,
   input  wire logic [0:0]                    csr_addr,
   input  wire logic [rle8_pkg::CSR_W-1:0]    csr_wdata
);
   import rle8_pkg::*;

   logic [CSR_W-1:0]  image_width_ff, image_width_in;
   logic [CSR_W-1:0]  image_height_ff, image_height_in;

   logic              pixel_accept;
   logic              cmd_push;
   logic              cmd_pop;
   cmd_type           new_cmd;
   cmd_type           head_cmd;
   queue_status_type  queue_status;

   // Dimension registers; the front part clamps them on use.
   always_comb begin
      image_width_in  = image_width_ff;
      image_height_in = image_height_ff;
      if (csr_we) begin
         case (csr_index_type'(csr_addr))
            CSR_IMAGE_WIDTH:  image_width_in  = csr_wdata;
            CSR_IMAGE_HEIGHT: image_height_in = csr_wdata;
            default: begin
               image_width_in  = image_width_ff;
               image_height_in = image_height_ff;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         image_width_ff  <= CSR_W'(1);
         image_height_ff <= CSR_W'(1);
      end else begin
         image_width_ff  <= image_width_in;
         image_height_ff <= image_height_in;
      end
   end

   // A pixel is taken whenever the queue can hold the command it may produce.
   assign req_tready   = !queue_status.full;
   assign pixel_accept = req_tvalid && req_tready;

   rle8_front #(
      .MAX_RUN  (MAX_RUN),
      .DIM_BITS (DIM_BITS)
   ) u_front (
      .clock        (clock),
      .reset        (reset),
      .pixel_accept (pixel_accept),
      .pixel_value  (req_tdata),
      .image_width  (image_width_ff),
      .image_height (image_height_ff),
      .cmd          (new_cmd),
      .cmd_push     (cmd_push)
   );

   rle8_queue u_queue (
      .clock    (clock),
      .reset    (reset),
      .push     (cmd_push),
      .push_cmd (new_cmd),
      .pop      (cmd_pop),
      .head_cmd (head_cmd),
      .status   (queue_status)
   );

   rle8_back u_back (
      .clock      (clock),
      .reset      (reset),
      .head_cmd   (head_cmd),
      .status     (queue_status),
      .pop        (cmd_pop),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tlast  (rsp_tlast)
   );

endmodule

`default_nettype wire

// ----- dv/rle8_bitmap_encoder_core_test.sv -----
// Self-checking testbench for the RLE8 bitmap encoder core.
`timescale 1ns / 1ps

module rle8_bitmap_encoder_core_test;

   import rle8_pkg::*;

   // The block is built with its default run limit and dimension width. The
   // predictor below uses the same values.
   localparam int MAX_RUN   = 255;
   localparam int DIM_BITS  = 14;
   localparam int DIM_LIMIT = 1 << DIM_BITS;
   localparam int DIM_MASK  = DIM_LIMIT - 1;

   // Cycles that wait_idle still waits after the last expected byte. A pixel that
   // made no byte pushes no command into the four-entry command queue.
   localparam int DRAIN_CYCLES = 24;

   // Cycle budget for the whole run; the run stops with an error when it is reached.
   localparam int CYCLE_LIMIT = 400000;

   // How the content of a group of pixels is chosen.
   typedef enum int {
      STYLE_NOISE,
      STYLE_SHORT_RUNS,
      STYLE_LONG_RUNS
   } pixel_style_type;

   // One byte of the encoded stream as the result channel should carry it.
   typedef struct packed {
      logic [BYTE_W-1:0] code;
      logic              closes_pixel;
   } stream_byte_type;

   logic              clock = 1'b0;
   logic              reset = 1'b1;
   logic              req_tvalid = 1'b0;
   logic              req_tready;
   logic [BYTE_W-1:0] req_tdata = '0;
   logic              rsp_tvalid;
   logic              rsp_tready = 1'b0;
   logic [BYTE_W-1:0] rsp_tdata;
   logic              rsp_tlast;
   logic              csr_we = 1'b0;
   logic [0:0]        csr_addr = CSR_IMAGE_WIDTH;
   logic [CSR_W-1:0]  csr_wdata = '0;

   rle8_bitmap_encoder_core #(
      .MAX_RUN  (MAX_RUN),
      .DIM_BITS (DIM_BITS)
   ) dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),    // [7:0] pixel_value
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),    // [7:0] out_byte
      .rsp_tlast  (rsp_tlast),    // last_of_item
      .csr_we     (csr_we),
      .csr_addr   (csr_addr),
      .csr_wdata  (csr_wdata)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // ------------------------------------------------------------------
   // Encoder predictor. It mirrors the two dimension registers and keeps
   // its own open run and pixel position. Every accepted pixel beat is fed
   // through it, and the bytes it produces are queued in arrival order.
   // ------------------------------------------------------------------
   logic [CSR_W-1:0]  width_reg  = 15'd1;
   logic [CSR_W-1:0]  height_reg = 15'd1;
   logic [BYTE_W-1:0] run_value  = '0;
   int                run_len    = 0;    // zero means no run is open
   int                col_idx    = 0;
   int                row_idx    = 0;

   logic [BYTE_W-1:0] pixel_bytes [$];   // bytes made by the pixel in hand
   stream_byte_type   expected_bytes [$];
   logic [BYTE_W-1:0] pixel_backlog [$];

   int error_count  = 0;
   int pixels_sent  = 0;
   int bytes_seen   = 0;
   int csr_writes   = 0;
   int cycle_count  = 0;

   // A register of zero behaves as one, and anything past the counter range
   // behaves as the largest size the counters can hold.
   function automatic int eff_dim(input logic [CSR_W-1:0] value);
      if (value == '0) return 1;
      if (int'(value) > DIM_LIMIT) return DIM_LIMIT;
      return int'(value);
   endfunction

   // Closes the open run, if any, as a count byte then a value byte.
   function automatic void flush_run();
      if (run_len != 0) begin
         pixel_bytes.push_back(BYTE_W'(run_len));
         pixel_bytes.push_back(run_value);
         run_len = 0;
      end
   endfunction

   function automatic void encode_pixel(input logic [BYTE_W-1:0] pixel);
      int row_w;
      int col_h;
      row_w = eff_dim(width_reg);
      col_h = eff_dim(height_reg);
      pixel_bytes.delete();

      // A new value ends the run that was growing.
      if (run_len != 0 && pixel != run_value) flush_run();
      if (run_len == 0) begin
         run_value = pixel;
         run_len = 1;
      end else begin
         run_len++;
      end
      // A full run is sent at once rather than waiting for the next pixel.
      if (run_len >= MAX_RUN) flush_run();

      // The position checks use "reaches or passes" so that a dimension made
      // smaller in the middle of an image ends the row or image right away.
      if (col_idx + 1 >= row_w) begin
         flush_run();
         col_idx = 0;
         pixel_bytes.push_back(BYTE_EOL);
         if (row_idx + 1 >= col_h) begin
            pixel_bytes.push_back(BYTE_EOB);
            row_idx = 0;
         end else begin
            pixel_bytes.push_back(BYTE_EOL);
            row_idx = (row_idx + 1) & DIM_MASK;
         end
      end else begin
         col_idx = (col_idx + 1) & DIM_MASK;
      end

      foreach (pixel_bytes[i])
         expected_bytes.push_back('{pixel_bytes[i], i == pixel_bytes.size() - 1});
   endfunction

   // ------------------------------------------------------------------
   // Pixel driver. Beats go out in bursts of random length separated by
   // random gaps; now and then a long burst runs with no gap at all. A beat
   // that is not taken is held unchanged until the block takes it.
   // ------------------------------------------------------------------
   int burst_left = 1;
   int gap_left   = 0;

   always @(posedge clock) begin
      if (reset) begin
         req_tvalid <= 1'b0;
      end else begin
         if (req_tvalid && req_tready) begin
            encode_pixel(req_tdata);
            pixels_sent++;
         end
         if (!req_tvalid || req_tready) begin
            if (gap_left > 0) begin
               gap_left--;
               req_tvalid <= 1'b0;
            end else if (pixel_backlog.size() != 0) begin
               req_tvalid <= 1'b1;
               req_tdata <= pixel_backlog.pop_front();
               burst_left--;
               if (burst_left <= 0) begin
                  if ($urandom_range(0, 7) == 0) begin
                     burst_left = 150;
                     gap_left = 0;
                  end else begin
                     burst_left = $urandom_range(1, 20);
                     gap_left = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 10);
                  end
               end
            end else begin
               req_tvalid <= 1'b0;
            end
         end
      end
   end

   // ------------------------------------------------------------------
   // Byte monitor. Every byte beat is matched against the oldest expected
   // byte. Back-pressure follows a rotating 16-bit pattern that is reloaded whenever
   // pattern_age reaches its limit: always ready, random, mostly stalled, or mostly ready.
   // ------------------------------------------------------------------
   logic [15:0] ready_pattern = 16'hFFFF;
   int          pattern_age   = 0;

   always @(posedge clock) begin
      stream_byte_type want;
      if (reset) begin
         rsp_tready <= 1'b0;
      end else begin
         if (rsp_tvalid && rsp_tready) begin
            bytes_seen++;
            if (expected_bytes.size() == 0) begin
               $error("unexpected byte beat: out_byte 0x%02h, last_of_item %0b",
                      rsp_tdata, rsp_tlast);
               error_count++;
            end else begin
               want = expected_bytes.pop_front();
               if (rsp_tdata !== want.code) begin
                  $error("out_byte mismatch: expected 0x%02h, actual 0x%02h",
                         want.code, rsp_tdata);
                  error_count++;
               end
               if (rsp_tlast !== want.closes_pixel) begin
                  $error("last_of_item mismatch: expected %0b, actual %0b",
                         want.closes_pixel, rsp_tlast);
                  error_count++;
               end
            end
         end
         pattern_age++;
         if (pattern_age >= 128) begin
            pattern_age = 0;
            case ($urandom_range(0, 3))
               0: ready_pattern = 16'hFFFF;
               1: ready_pattern = 16'($urandom);
               2: ready_pattern = 16'($urandom) & 16'($urandom);
               default: ready_pattern = 16'($urandom) | 16'($urandom);
            endcase
         end else begin
            ready_pattern = {ready_pattern[0], ready_pattern[15:1]};
         end
         rsp_tready <= ready_pattern[0];
      end
   end

   // The run stops here if the block hangs or bytes go missing.
   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("Timeout with %0d bytes still expected", expected_bytes.size());
         $display("Testbench completed WITH ERRORS");
         $finish;
      end
   end

   // ------------------------------------------------------------------
   // Stimulus helpers.
   // ------------------------------------------------------------------

   // Writes one dimension register. Only called while the block is idle, so
   // the mirror can follow the write at once.
   task automatic write_dim(input csr_index_type index, input logic [CSR_W-1:0] value);
      @(posedge clock);
      csr_we <= 1'b1;
      csr_addr <= index;
      csr_wdata <= value;
      @(posedge clock);
      csr_we <= 1'b0;
      if (index == CSR_IMAGE_WIDTH) width_reg = value;
      else height_reg = value;
      csr_writes++;
   endtask

   // Holds off until every queued pixel is taken and every expected byte has
   // arrived, then lets the command queue drain.
   task automatic wait_idle();
      do @(posedge clock);
      while (pixel_backlog.size() != 0 || req_tvalid || expected_bytes.size() != 0);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   task automatic push_pixels(input int count, input pixel_style_type style);
      int                left;
      int                len;
      logic [BYTE_W-1:0] value;
      left = count;
      while (left > 0) begin
         case (style)
            STYLE_NOISE: begin
               value = BYTE_W'($urandom);
               len = 1;
            end
            STYLE_SHORT_RUNS: begin
               // Four values, both extremes among them, so runs of equal
               // pixels form often and also break often.
               value = BYTE_W'($urandom_range(0, 3) * 8'h55);
               len = $urandom_range(1, 6);
            end
            default: begin
               value = BYTE_W'($urandom);
               len = $urandom_range(1, 300);
            end
         endcase
         if (len > left) len = left;
         repeat (len) pixel_backlog.push_back(value);
         left -= len;
      end
   endtask

   // Mostly small images, sometimes medium ones, and now and then a zero or
   // an oversized register value.
   function automatic logic [CSR_W-1:0] pick_dim(input int common_max);
      int pick;
      pick = $urandom_range(0, 9);
      if (pick < 6) return CSR_W'($urandom_range(1, common_max));
      if (pick < 8) return CSR_W'($urandom_range(common_max + 1, 300));
      if (pick == 8) return '0;
      return CSR_W'($urandom_range(DIM_LIMIT, 32767));
   endfunction

   // ------------------------------------------------------------------
   // Test sequence.
   // ------------------------------------------------------------------
   initial begin
      int                random_pixels;
      int                image_pixels;
      int                count;
      pixel_style_type   style;
      logic [BYTE_W-1:0] two_row_pixels [8];

      repeat (6) @(posedge clock);
      reset <= 1'b0;

      // Reset dimensions are one by one, so each pixel is a whole image.
      pixel_backlog.push_back(8'h00);
      pixel_backlog.push_back(8'hFF);
      wait_idle();

      // A two-row image: runs merge within a row, and the second row ends
      // with the end-of-image marker instead of end-of-line.
      write_dim(CSR_IMAGE_WIDTH, 15'd4);
      write_dim(CSR_IMAGE_HEIGHT, 15'd2);
      two_row_pixels = '{8'h11, 8'h11, 8'h22, 8'h22, 8'h33, 8'h44, 8'h44, 8'h44};
      foreach (two_row_pixels[i])
         pixel_backlog.push_back(two_row_pixels[i]);
      wait_idle();

      // The last pixel of a row differs from the open run: two run flushes
      // and a marker pair, six bytes from one pixel.
      write_dim(CSR_IMAGE_WIDTH, 15'd3);
      pixel_backlog.push_back(8'h05);
      pixel_backlog.push_back(8'h05);
      pixel_backlog.push_back(8'h07);
      wait_idle();

      // Zero dimensions act as one; the image ends on the very next pixel
      // even though the row counter already stands past the new height.
      write_dim(CSR_IMAGE_WIDTH, 15'd0);
      write_dim(CSR_IMAGE_HEIGHT, 15'd0);
      pixel_backlog.push_back(8'h80);
      wait_idle();

      // Oversized dimensions, then both shrunk in the middle of an image.
      write_dim(CSR_IMAGE_WIDTH, 15'd16385);
      write_dim(CSR_IMAGE_HEIGHT, 15'd32767);
      pixel_backlog.push_back(8'h55);
      pixel_backlog.push_back(8'h55);
      pixel_backlog.push_back(8'hAA);
      wait_idle();
      write_dim(CSR_IMAGE_WIDTH, 15'd2);
      pixel_backlog.push_back(8'hAA);
      wait_idle();
      write_dim(CSR_IMAGE_HEIGHT, 15'd2);
      pixel_backlog.push_back(8'h01);
      pixel_backlog.push_back(8'h02);
      wait_idle();

      // A run longer than the run limit in a maximum-width row, then the
      // width and height brought down to one with the counters far along.
      random_pixels = 0;
      write_dim(CSR_IMAGE_WIDTH, 15'(DIM_LIMIT));
      write_dim(CSR_IMAGE_HEIGHT, 15'(DIM_LIMIT));
      repeat (260) pixel_backlog.push_back(8'h3C);
      push_pixels(12, STYLE_NOISE);
      wait_idle();
      write_dim(CSR_IMAGE_WIDTH, 15'd1);
      push_pixels(1, STYLE_NOISE);
      wait_idle();
      write_dim(CSR_IMAGE_HEIGHT, 15'd1);
      push_pixels(1, STYLE_NOISE);
      wait_idle();
      random_pixels += 274;

      // Random phases. Most push whole images with random content; some are
      // cut short, so the next register change lands in the middle of an
      // image. Each phase ends with the sender held until all bytes are in.
      while (random_pixels < 380) begin
         if ($urandom_range(0, 3) != 0) write_dim(CSR_IMAGE_WIDTH, pick_dim(12));
         if ($urandom_range(0, 3) != 0) write_dim(CSR_IMAGE_HEIGHT, pick_dim(4));
         image_pixels = eff_dim(width_reg) * eff_dim(height_reg);
         if (image_pixels <= 96) count = image_pixels * $urandom_range(1, 2);
         else count = $urandom_range(8, 60);
         if ($urandom_range(0, 5) == 0) count = $urandom_range(1, count);
         style = pixel_style_type'($urandom_range(0, 2));
         push_pixels(count, style);
         random_pixels += count;
         wait_idle();
      end

      $display("Encoded %0d pixels into %0d stream bytes over %0d register writes,",
               pixels_sent, bytes_seen, csr_writes);
      $display("with zero, oversized and mid-image dimension changes and full-length runs.");
      if (error_count == 0) begin
         $display("Testbench completed without errors");
      end else begin
         $display("Testbench completed WITH ERRORS");
      end
      $finish;
   end

endmodule
